[rtl/core/rotation_matrix_to_quaternion_macros.svh]
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RMQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rmq_pkg.sv]
// shared widths and types for the rotation matrix to quaternion block
package rmq_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_W     = DATA_WIDTH - 2;
    localparam int GUARD_W    = DATA_WIDTH - FRAC_W;
    localparam int TRACE_W    = DATA_WIDTH + 2;
    localparam int NUM_W      = DATA_WIDTH + 1;
    localparam int ARG_W      = DATA_WIDTH + 4;
    localparam int ARGU_W     = ARG_W - 1;
    localparam int RAD_SH     = FRAC_W - 2;
    localparam int ROOT_W     = (ARGU_W + RAD_SH + 1) / 2;
    localparam int DIV_W      = ROOT_W + 2;

    // which component carries the square root
    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_S = 2'd3
    } sel_t;

    // side data traveling next to the square root pipeline
    typedef struct packed {
        sel_t                        k;
        logic                        invalid;
        logic [2:0]                  neg;
        logic [2:0][NUM_W-1:0]       mag;
    } sba_t;

    // side data traveling next to the dividers
    typedef struct packed {
        sel_t                        k;
        logic                        invalid;
        logic [2:0]                  neg;
        logic [DATA_WIDTH-1:0]       q;
    } sbb_t;

    // one result
    typedef struct packed {
        logic [DATA_WIDTH-1:0] qs;
        logic [DATA_WIDTH-1:0] qx;
        logic [DATA_WIDTH-1:0] qy;
        logic [DATA_WIDTH-1:0] qz;
        logic                  invalid;
    } quat_t;

endpackage

[rtl/core/rmq_mat_if.sv]
// matrix request channel
interface rmq_mat_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m00;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m01;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m02;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m10;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m11;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m12;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m20;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m21;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

[rtl/core/rmq_quat_if.sv]
// quaternion result channel
interface rmq_quat_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  qs;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  qx;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  qy;
    logic signed [rmq_pkg::DATA_WIDTH-1:0]  qz;
    logic                                   invalid;

    modport source (output valid, qs, qx, qy, qz, invalid, input ready);
    modport sink   (input valid, qs, qx, qy, qz, invalid, output ready);
endinterface

[rtl/core/rmq_sqrt.sv]
// pipelined integer square root, one root bit per stage
module rmq_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rmq_pkg::ARGU_W-1:0]  arg,
    output logic [rmq_pkg::ROOT_W-1:0]  root
);
    localparam int R  = rmq_pkg::ROOT_W;
    localparam int XW = 2 * R;
    localparam int RW = R + 2;
    localparam int TW = RW + 2;

    logic [XW-1:0] x_reg    [0:R];
    logic [RW-1:0] rem_reg  [0:R];
    logic [R-1:0]  root_reg [0:R];
    logic [XW-1:0] x_next    [0:R-1];
    logic [RW-1:0] rem_next  [0:R-1];
    logic [R-1:0]  root_next [0:R-1];
    logic [TW-1:0] tmp_w    [0:R-1];
    logic [TW-1:0] trial_w  [0:R-1];

    // one restoring step per stage
    always_comb
    begin
        for (int s = 0; s < R; s++)
        begin
            tmp_w[s]   = {rem_reg[s], x_reg[s][XW-1:XW-2]};
            trial_w[s] = TW'({root_reg[s], 2'b01});
            x_next[s]  = x_reg[s] << 2;
            if (tmp_w[s] >= trial_w[s])
            begin
                rem_next[s]  = RW'(tmp_w[s] - trial_w[s]);
                root_next[s] = {root_reg[s][R-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = RW'(tmp_w[s]);
                root_next[s] = {root_reg[s][R-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= XW'(arg) << rmq_pkg::RAD_SH;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int s = 0; s < R; s++)
            begin
                x_reg[s+1]    <= x_next[s];
                rem_reg[s+1]  <= rem_next[s];
                root_reg[s+1] <= root_next[s];
            end
        end
    end

    assign root = root_reg[R];
endmodule

[rtl/core/rmq_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module rmq_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic [rmq_pkg::DIV_W-1:0]       d,
    input  logic [rmq_pkg::NUM_W-1:0]       mag,
    output logic [rmq_pkg::DATA_WIDTH-1:0]  quot,
    output logic                            ovf
);
    localparam int W  = rmq_pkg::DATA_WIDTH;
    localparam int DW = rmq_pkg::DIV_W;
    localparam int GB = rmq_pkg::GUARD_W;
    localparam int HW = rmq_pkg::NUM_W - GB;

    logic [DW-1:0] d_reg    [0:W];
    logic [DW-1:0] rem_reg  [0:W];
    logic [W-1:0]  low_reg  [0:W];
    logic [W-1:0]  quot_reg [0:W];
    logic          ovf_reg  [0:W];
    logic [DW-1:0] rem_next  [0:W-1];
    logic [W-1:0]  quot_next [0:W-1];
    logic [DW:0]   tmp_w     [0:W-1];
    logic [HW-1:0] hi_w;

    // high part of mag * 2^frac; quotient overflows the width when it reaches d
    assign hi_w = mag[rmq_pkg::NUM_W-1:GB];

    // one restoring step per stage
    always_comb
    begin
        for (int s = 0; s < W; s++)
        begin
            tmp_w[s] = {rem_reg[s], low_reg[s][W-1]};
            if (tmp_w[s] >= {1'b0, d_reg[s]})
            begin
                rem_next[s]  = DW'(tmp_w[s] - {1'b0, d_reg[s]});
                quot_next[s] = {quot_reg[s][W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = DW'(tmp_w[s]);
                quot_next[s] = {quot_reg[s][W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= d;
            rem_reg[0]  <= DW'(hi_w);
            low_reg[0]  <= {mag[GB-1:0], {rmq_pkg::FRAC_W{1'b0}}};
            quot_reg[0] <= '0;
            ovf_reg[0]  <= (DW'(hi_w) >= d);
            for (int s = 0; s < W; s++)
            begin
                d_reg[s+1]    <= d_reg[s];
                rem_reg[s+1]  <= rem_next[s];
                low_reg[s+1]  <= low_reg[s] << 1;
                quot_reg[s+1] <= quot_next[s];
                ovf_reg[s+1]  <= ovf_reg[s];
            end
        end
    end

    assign quot = quot_reg[W];
    assign ovf  = ovf_reg[W];
endmodule

[rtl/core/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix to quaternion, Shepperd's method, fixed point
//
// Channels: mat takes one 3x3 matrix per request (nine signed Q1.30 entries,
// 1.0 = 2^30); quat returns one quaternion per request (qs, qx, qy, qz in
// Q1.30) plus an invalid flag. Both use valid/ready; a request moves when
// valid and ready are high at a rising edge of clk.
// Throughput: one request per cycle while the skid register is empty, items
// independent. Results pass through the square root pipeline (one root bit
// per stage, 32 stages) and the dividers behind it (one quotient bit per
// stage, 32 stages).
// A request whose square-root argument is not positive returns all zeros
// with invalid set.
// Reset (rst_n low, asynchronous) empties the pipeline and the output stage.
// When the receiver stalls, the finished result holds on quat and one more
// result lands in a skid register; only then does the whole pipeline freeze
// and mat.ready drop. Nothing is lost or repeated.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic           clk,
    input  logic           rst_n,
    rmq_mat_if.sink        mat,
    rmq_quat_if.source     quat
);
    localparam int W  = rmq_pkg::DATA_WIDTH;
    localparam int TW = rmq_pkg::TRACE_W;
    localparam int NW = rmq_pkg::NUM_W;
    localparam int AW = rmq_pkg::ARG_W;
    localparam int R  = rmq_pkg::ROOT_W;
    localparam int NV = 5 + R + W;
    localparam logic signed [AW-1:0] ONE =
        {{(AW-rmq_pkg::FRAC_W-1){1'b0}}, 1'b1, {rmq_pkg::FRAC_W{1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } mat_t;

    typedef struct packed {
        logic signed [TW-1:0] t;
        logic signed [W-1:0]  c0, c1, c2;
        logic signed [NW-1:0] p01, p02, p12, d12, d02, d01;
    } st1_t;

    typedef struct packed {
        rmq_pkg::sel_t        k;
        logic signed [TW-1:0] t;
        logic signed [W-1:0]  c0, c1, c2;
        logic signed [NW-1:0] p01, p02, p12, d12, d02, d01;
    } st2_t;

    logic                   en;
    logic                   v_reg [0:NV-1];
    mat_t                   s0_reg;
    st1_t                   s1_reg, s1_next;
    st2_t                   s2_reg, s2_next;
    rmq_pkg::sba_t          sba_reg [0:R];
    rmq_pkg::sba_t          sba_next;
    rmq_pkg::sbb_t          sbb_reg [0:W];
    rmq_pkg::sbb_t          sbb_next;
    logic [rmq_pkg::ARGU_W-1:0] sq_arg;
    logic signed [AW-1:0]   arg_w;
    logic signed [W-1:0]    cm_w;
    logic signed [NW-1:0]   num_w [0:2];
    logic signed [TW-1:0]   e0, e1, e2;
    logic [R-1:0]           root_w;
    logic [W-1:0]           quot_w [0:2];
    logic                   ovf_w  [0:2];
    logic [W-1:0]           r_w    [0:2];
    rmq_pkg::quat_t         res_next;
    rmq_pkg::quat_t         out_reg, skid_reg;
    logic                   out_v_reg, skid_v_reg;

    // saturate a quotient magnitude into a signed component
    function automatic logic [W-1:0] sat_res(input logic [W-1:0] qv,
                                             input logic ov, input logic ng);
        logic [W-1:0] res;
        if (ng)
        begin
            if (ov || (qv[W-1] && (|qv[W-2:0])))
                res = {1'b1, {(W-1){1'b0}}};
            else
                res = -qv;
        end
        else
        begin
            if (ov || qv[W-1])
                res = {1'b0, {(W-1){1'b1}}};
            else
                res = qv;
        end
        return res;
    endfunction

    // pipeline moves unless the skid register is holding a result
    assign en        = !skid_v_reg;
    assign mat.ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= mat.valid;
            for (int i = 1; i < NV; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // stage 1: trace and off-diagonal sums and differences
    always_comb
    begin
        s1_next.t   = TW'(s0_reg.m00) + TW'(s0_reg.m11) + TW'(s0_reg.m22);
        s1_next.c0  = s0_reg.m00;
        s1_next.c1  = s0_reg.m11;
        s1_next.c2  = s0_reg.m22;
        s1_next.p01 = NW'(s0_reg.m10) + NW'(s0_reg.m01);
        s1_next.p02 = NW'(s0_reg.m02) + NW'(s0_reg.m20);
        s1_next.p12 = NW'(s0_reg.m21) + NW'(s0_reg.m12);
        s1_next.d12 = NW'(s0_reg.m21) - NW'(s0_reg.m12);
        s1_next.d02 = NW'(s0_reg.m02) - NW'(s0_reg.m20);
        s1_next.d01 = NW'(s0_reg.m10) - NW'(s0_reg.m01);
    end

    // stage 2: largest of the diagonal and the trace, earliest on a tie
    assign e0 = TW'(s1_reg.c0);
    assign e1 = TW'(s1_reg.c1);
    assign e2 = TW'(s1_reg.c2);

    always_comb
    begin
        s2_next.t   = s1_reg.t;
        s2_next.c0  = s1_reg.c0;
        s2_next.c1  = s1_reg.c1;
        s2_next.c2  = s1_reg.c2;
        s2_next.p01 = s1_reg.p01;
        s2_next.p02 = s1_reg.p02;
        s2_next.p12 = s1_reg.p12;
        s2_next.d12 = s1_reg.d12;
        s2_next.d02 = s1_reg.d02;
        s2_next.d01 = s1_reg.d01;
        if (e0 >= e1 && e0 >= e2 && e0 >= s1_reg.t)
            s2_next.k = rmq_pkg::SEL_X;
        else if (e1 > e0 && e1 >= e2 && e1 >= s1_reg.t)
            s2_next.k = rmq_pkg::SEL_Y;
        else if (e2 > e0 && e2 > e1 && e2 >= s1_reg.t)
            s2_next.k = rmq_pkg::SEL_Z;
        else
            s2_next.k = rmq_pkg::SEL_S;
    end

    // stage 3: square root argument and divider numerators
    always_comb
    begin
        case (s2_reg.k)
            rmq_pkg::SEL_X:
            begin
                cm_w     = s2_reg.c0;
                num_w[0] = s2_reg.p01;
                num_w[1] = s2_reg.p02;
                num_w[2] = s2_reg.d12;
            end
            rmq_pkg::SEL_Y:
            begin
                cm_w     = s2_reg.c1;
                num_w[0] = s2_reg.p01;
                num_w[1] = s2_reg.p12;
                num_w[2] = s2_reg.d02;
            end
            rmq_pkg::SEL_Z:
            begin
                cm_w     = s2_reg.c2;
                num_w[0] = s2_reg.p02;
                num_w[1] = s2_reg.p12;
                num_w[2] = s2_reg.d01;
            end
            default:
            begin
                cm_w     = s2_reg.c0;
                num_w[0] = s2_reg.d12;
                num_w[1] = s2_reg.d02;
                num_w[2] = s2_reg.d01;
            end
        endcase
        if (s2_reg.k == rmq_pkg::SEL_S)
            arg_w = AW'(s2_reg.t) + ONE;
        else
            arg_w = (AW'(cm_w) <<< 1) - AW'(s2_reg.t) + ONE;
        sba_next.k       = s2_reg.k;
        sba_next.invalid = arg_w[AW-1] || (arg_w == '0);
        for (int j = 0; j < 3; j++)
        begin
            sba_next.neg[j] = num_w[j][NW-1];
            sba_next.mag[j] = num_w[j][NW-1] ? NW'(-num_w[j]) : NW'(num_w[j]);
        end
        sq_arg = sba_next.invalid ? '0 : arg_w[rmq_pkg::ARGU_W-1:0];
    end

    // front stage registers and side data shift lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg.m00 <= mat.m00;
            s0_reg.m01 <= mat.m01;
            s0_reg.m02 <= mat.m02;
            s0_reg.m10 <= mat.m10;
            s0_reg.m11 <= mat.m11;
            s0_reg.m12 <= mat.m12;
            s0_reg.m20 <= mat.m20;
            s0_reg.m21 <= mat.m21;
            s0_reg.m22 <= mat.m22;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            sba_reg[0] <= sba_next;
            for (int i = 1; i <= R; i++)
                sba_reg[i] <= sba_reg[i-1];
            sbb_reg[0] <= sbb_next;
            for (int i = 1; i <= W; i++)
                sbb_reg[i] <= sbb_reg[i-1];
        end
    end

    // square root of the chosen argument
    rmq_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .arg  (sq_arg),
        .root (root_w)
    );

    // side data for the divider stages
    always_comb
    begin
        sbb_next.k       = sba_reg[R].k;
        sbb_next.invalid = sba_reg[R].invalid;
        sbb_next.neg     = sba_reg[R].neg;
        sbb_next.q       = W'(root_w);
    end

    // three dividers by four times the root
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        rmq_div u_div (
            .clk  (clk),
            .en   (en),
            .d    ({root_w, 2'b00}),
            .mag  (sba_reg[R].mag[g]),
            .quot (quot_w[g]),
            .ovf  (ovf_w[g])
        );
    end

    // final saturation and placement of the components
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            r_w[j] = sat_res(quot_w[j], ovf_w[j], sbb_reg[W].neg[j]);
        res_next.invalid = sbb_reg[W].invalid;
        case (sbb_reg[W].k)
            rmq_pkg::SEL_X:
            begin
                res_next.qx = sbb_reg[W].q;
                res_next.qy = r_w[0];
                res_next.qz = r_w[1];
                res_next.qs = r_w[2];
            end
            rmq_pkg::SEL_Y:
            begin
                res_next.qy = sbb_reg[W].q;
                res_next.qx = r_w[0];
                res_next.qz = r_w[1];
                res_next.qs = r_w[2];
            end
            rmq_pkg::SEL_Z:
            begin
                res_next.qz = sbb_reg[W].q;
                res_next.qx = r_w[0];
                res_next.qy = r_w[1];
                res_next.qs = r_w[2];
            end
            default:
            begin
                res_next.qs = sbb_reg[W].q;
                res_next.qx = r_w[0];
                res_next.qy = r_w[1];
                res_next.qz = r_w[2];
            end
        endcase
        if (sbb_reg[W].invalid)
        begin
            res_next.qs = '0;
            res_next.qx = '0;
            res_next.qy = '0;
            res_next.qz = '0;
        end
    end

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && !quat.ready)
        begin
            if (en && v_reg[NV-1])
                skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[NV-1];
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_v_reg && !quat.ready)
        begin
            if (en && v_reg[NV-1] && !skid_v_reg)
                skid_reg <= res_next;
        end
        else if (skid_v_reg)
            out_reg <= skid_reg;
        else
            out_reg <= res_next;
    end

    assign quat.valid   = out_v_reg;
    assign quat.qs      = out_reg.qs;
    assign quat.qx      = out_reg.qx;
    assign quat.qy      = out_reg.qy;
    assign quat.qz      = out_reg.qz;
    assign quat.invalid = out_reg.invalid;

    `RMQ_ASSERT_IMP(a_skid_needs_out, skid_v_reg, out_v_reg, "skid full with empty output")
    `RMQ_ASSERT_NXT(a_skid_catch, out_v_reg && !quat.ready && !skid_v_reg && v_reg[NV-1], skid_v_reg, "stalled result not caught in skid")
    `RMQ_ASSERT_NXT(a_skid_drain, skid_v_reg && quat.ready, !skid_v_reg && out_v_reg, "skid not drained")
    `RMQ_ASSERT_IMP(a_invalid_zero, quat.valid && quat.invalid, quat.qs == '0 && quat.qx == '0 && quat.qy == '0 && quat.qz == '0, "invalid result not zero")

endmodule

[verif/tb_rotation_matrix_to_quaternion.sv]
// testbench for the rotation matrix to quaternion block: random and directed matrices
`timescale 1ns / 100ps

// expected quaternions, predicted from each accepted matrix
class quat_scoreboard;
    rmq_pkg::quat_t pending_quats[$];
    int unsigned    mismatch_count;
    int unsigned    checked_count;
    int unsigned    invalid_count;
    int unsigned    sel_hits[4];

    // bit b of a * 2^sh
    static function bit shifted_bit(logic [63:0] a, int sh, int b);
        if (b < sh || b - sh >= 64)
            return 1'b0;
        return a[b - sh];
    endfunction

    // floor(sqrt(a * 2^sh)), bit by bit
    static function logic [63:0] root_of(logic [63:0] a, int sh);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | {shifted_bit(a, sh, 2*i+1), shifted_bit(a, sh, 2*i)};
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // (num * 2^F) / (4 * q), truncated toward zero, saturated
    static function logic [31:0] scaled_quotient(longint num, logic [63:0] q);
        logic [63:0] divisor;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] quot;
        logic [63:0] rem;
        bit          sat;
        longint      res;
        divisor = q << 2;
        mag     = (num < 0) ? -num : num;
        lim     = 64'd1 << (rmq_pkg::DATA_WIDTH - 1);
        quot    = '0;
        rem     = '0;
        sat     = 1'b0;
        for (int b = 127; b >= 0 && !sat; b--) begin
            rem  = (rem << 1) | shifted_bit(mag, rmq_pkg::FRAC_W, b);
            quot = quot << 1;
            if (rem >= divisor) begin
                rem  = rem - divisor;
                quot = quot | 64'd1;
            end
            if (quot > lim)
                sat = 1'b1;
        end
        if (num < 0)
            res = sat ? -longint'(lim) : -longint'(quot);
        else
            res = (sat || quot >= lim) ? longint'(lim - 1) : longint'(quot);
        return res[31:0];
    endfunction

    // predict the quaternion of one accepted matrix
    function void note_matrix(logic signed [31:0] m[9]);
        longint         a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint         trace, arg, cand[4];
        logic [63:0]    q;
        rmq_pkg::sel_t  sel;
        rmq_pkg::quat_t res;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        trace = a00 + a11 + a22;
        cand[0] = a00; cand[1] = a11; cand[2] = a22; cand[3] = trace;
        sel = rmq_pkg::SEL_X;
        for (int i = 1; i < 4; i++)
            if (cand[sel] < cand[i])
                sel = rmq_pkg::sel_t'(i);
        arg = (sel == rmq_pkg::SEL_S) ? trace + (64'sd1 <<< rmq_pkg::FRAC_W)
                                      : 2*cand[sel] - trace + (64'sd1 <<< rmq_pkg::FRAC_W);
        res = '0;
        if (arg > 0) begin
            sel_hits[sel]++;
            q = root_of(arg, rmq_pkg::RAD_SH);
            case (sel)
                rmq_pkg::SEL_X: begin
                    res.qx = q[31:0];
                    res.qy = scaled_quotient(a10 + a01, q);
                    res.qz = scaled_quotient(a02 + a20, q);
                    res.qs = scaled_quotient(a21 - a12, q);
                end
                rmq_pkg::SEL_Y: begin
                    res.qy = q[31:0];
                    res.qx = scaled_quotient(a10 + a01, q);
                    res.qz = scaled_quotient(a21 + a12, q);
                    res.qs = scaled_quotient(a02 - a20, q);
                end
                rmq_pkg::SEL_Z: begin
                    res.qz = q[31:0];
                    res.qx = scaled_quotient(a02 + a20, q);
                    res.qy = scaled_quotient(a21 + a12, q);
                    res.qs = scaled_quotient(a10 - a01, q);
                end
                default: begin
                    res.qs = q[31:0];
                    res.qx = scaled_quotient(a21 - a12, q);
                    res.qy = scaled_quotient(a02 - a20, q);
                    res.qz = scaled_quotient(a10 - a01, q);
                end
            endcase
        end else begin
            res.invalid = 1'b1;
            invalid_count++;
        end
        pending_quats.push_back(res);
    endfunction

    // compare one accepted quaternion with the oldest prediction
    function void check_quat(rmq_pkg::quat_t got);
        rmq_pkg::quat_t want;
        checked_count++;
        if (pending_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected quaternion %h", got);
            return;
        end
        want = pending_quats.pop_front();
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch #%0d: expected s=%h x=%h y=%h z=%h inv=%b, got s=%h x=%h y=%h z=%h inv=%b",
                         checked_count, want.qs, want.qx, want.qy, want.qz, want.invalid,
                         got.qs, got.qx, got.qy, got.qz, got.invalid);
        end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion;
    localparam int  ONE       = 1 << rmq_pkg::FRAC_W;
    localparam int  NUM_RAND  = 1750;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    rmq_mat_if  mat ();
    rmq_quat_if quat ();

    quat_scoreboard board;
    longint         cycle_count;
    int unsigned    sent_count;
    bit             stimulus_done;

    rotation_matrix_to_quaternion u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat),
        .quat  (quat)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // random entry: full range, or near unit scale
    function automatic logic signed [31:0] rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $urandom;
        if (r == 3)
            return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        return $signed($urandom_range(0, 2*ONE)) - ONE;
    endfunction

    // send one matrix request, waits for the handshake
    task automatic send_matrix(logic signed [31:0] m[9]);
        mat.valid <= 1'b1;
        mat.m00 <= m[0]; mat.m01 <= m[1]; mat.m02 <= m[2];
        mat.m10 <= m[3]; mat.m11 <= m[4]; mat.m12 <= m[5];
        mat.m20 <= m[6]; mat.m21 <= m[7]; mat.m22 <= m[8];
        do
            @(posedge clk);
        while (!mat.ready);
        board.note_matrix(m);
        sent_count++;
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            mat.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // directed matrices: rotations, zeros, ties and extreme entries
    task automatic send_directed();
        logic signed [31:0] m[9];
        // identity
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                     send_matrix(m);
        // half turns about x, y, z
        m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};                   send_matrix(m);
        m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};                   send_matrix(m);
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};                   send_matrix(m);
        // quarter turn about z
        m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};                    send_matrix(m);
        // all zero: x wins the tie with arg one
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                           send_matrix(m);
        // ties on the diagonal
        m = '{ONE/2, 5, 7, 9, ONE/2, 11, 13, 17, ONE/2};            send_matrix(m);
        // all diagonal entries negative
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};                  send_matrix(m);
        m = '{32'sh80000000, 1, 2, 3, 32'sh80000000, 4, 5, 6, 32'sh80000000};
        send_matrix(m);
        // largest values everywhere
        for (int i = 0; i < 9; i++) m[i] = 32'sh7fffffff;           send_matrix(m);
        // extreme off diagonal entries with the diagonal at minus one half
        m = '{-ONE/2, 32'sh80000000, 32'sh80000000, 32'sh80000000, -ONE/2,
              32'sh80000000, 32'sh80000000, 32'sh80000000, -ONE/2};
        send_matrix(m);
        m = '{-ONE/2, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, -ONE/2,
              32'sh7fffffff, 32'sh80000000, 32'sh80000000, -ONE/2};
        send_matrix(m);
        // each diagonal entry at its largest value
        m = '{32'sh7fffffff, -1, 1, 32'sh80000000, 0, 32'sh7fffffff, 0, -1, 0};
        send_matrix(m);
        m = '{0, 32'sh55555555, 0, 32'shaaaaaaaa, 32'sh7fffffff, 0, 0, 0, 0};
        send_matrix(m);
        m = '{0, 0, 32'shaaaaaaaa, 0, 0, 0, 32'sh55555555, 0, 32'sh7fffffff};
        send_matrix(m);
        mat.valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic signed [31:0] m[9];
        int r;
        board = new();
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        sent_count = 0;
        mat.valid = 1'b0;
        mat.m00 = '0; mat.m01 = '0; mat.m02 = '0;
        mat.m10 = '0; mat.m11 = '0; mat.m12 = '0;
        mat.m20 = '0; mat.m21 = '0; mat.m22 = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int n = 0; n < NUM_RAND; n++) begin
            r = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++) m[i] = rand_entry();
            // small off diagonal, diagonal entries kept random
            if (r < 4) begin
                for (int i = 0; i < 9; i++)
                    if (i % 4 != 0) m[i] = $signed($urandom_range(0, ONE)) - ONE/2;
            end
            send_matrix(m);
            // drain once mid run
            if (n == NUM_RAND/2) begin
                mat.valid <= 1'b0;
                while (board.pending_quats.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end else if (n % 300 < 150) begin
                idle_sender(gap_len());
            end
        end
        mat.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // result side stalls
    initial begin
        int stall;
        quat.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (stall > 0) begin
                quat.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            quat.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // result check
    always @(posedge clk) begin
        if (rst_n && quat.valid && quat.ready)
            board.check_quat('{quat.qs, quat.qx, quat.qy, quat.qz, quat.invalid});
    end

    // end of run and cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[rotation_matrix_to_quaternion] ERROR");
                $finish;
            end
            if (stimulus_done && board.pending_quats.size() == 0) begin
                repeat (150) @(posedge clk);
                $display("%0d matrices sent, %0d quaternions checked, %0d invalid",
                         sent_count, board.checked_count, board.invalid_count);
                $display("root on x/y/z/s: %0d/%0d/%0d/%0d, %0d mismatches",
                         board.sel_hits[0], board.sel_hits[1], board.sel_hits[2],
                         board.sel_hits[3], board.mismatch_count);
                if (board.mismatch_count == 0 && board.pending_quats.size() == 0)
                    $display("[rotation_matrix_to_quaternion] OK");
                else
                    $display("[rotation_matrix_to_quaternion] ERROR");
                $finish;
            end
        end
    end
endmodule
